// ===== hw/rtl/sha256_stream_hasher_top_assert.svh =====
// Assertion macros shared by the checker of the stream hasher.
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH

// Check cons on the cycle after ante, outside reset.
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check cons in the same cycle as ante, outside reset.
`define SHS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons on the cycle after reset is applied.
`define SHS_ASSERT_AFTER_RESET(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/shs_pkg.sv =====
package shs_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [5:0] LAST_RND  = 6'd63;
    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [2:0] LAST_IDX  = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_req;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_rsp;

    // head of the request queue as seen by the engine
    typedef struct packed {
        logic    valid;
        t_in_req req;
    } t_queue_head;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN,
        PAD_DONE
    } t_pad_stage;

    localparam logic [31:0] IV_TABLE [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

endpackage

// ===== hw/rtl/shs_front.sv =====
module shs_front import shs_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_req     i_req,
    output t_queue_head o_head,
    input  logic        i_pop
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_in_req       r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic push;
    logic pop;

    // drop requests that carry neither a byte nor a close
    assign push    = i_valid && !o_stall && (i_req.byte_valid || i_req.end_of_message);
    assign pop     = i_pop && o_head.valid;
    assign o_stall = (r_count == CW'(DEPTH));

    assign o_head.valid = (r_count != '0);
    assign o_head.req   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/shs_back.sv =====
module shs_back import shs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_head i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_rsp    o_rsp
);

    function automatic logic [31:0] big0(input logic [31:0] x);
        big0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big1(input logic [31:0] x);
        big1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] sml0(input logic [31:0] x);
        sml0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] sml1(input logic [31:0] x);
        sml1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    t_state      r_state;
    t_state      n_state;
    t_pad_stage  r_pad;
    t_pad_stage  n_pad;
    logic        r_closing;
    logic [5:0]  r_fill;
    logic [63:0] r_len;
    logic [2:0]  r_len_cnt;
    logic [5:0]  r_round;
    logic [2:0]  r_emit_idx;
    logic [31:0] r_chain [8];
    logic [511:0] r_blk;
    logic [31:0] r_wv [8];
    logic        r_out_valid;
    t_out_rsp    r_out;

    logic        put_en;
    logic [7:0]  put_byte;
    logic        blk_full;
    logic        take_close;
    logic        len_add;
    logic        len_shift;
    logic        out_load;
    logic        restart;
    logic [5:0]  fill_next;

    logic [31:0] w_cur;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;

    assign fill_next = r_fill + 6'd1;
    assign blk_full  = put_en && (r_fill == LAST_POS);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    if (blk_full) begin
                        n_state = ST_ROUND;
                    end else if (i_head.req.end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (blk_full) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_round == LAST_RND) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (!r_closing) begin
                    n_state = ST_IDLE;
                end else if (r_pad == PAD_DONE) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_EMIT: begin
                if (out_load && r_emit_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop      = 1'b0;
        put_en     = 1'b0;
        put_byte   = 8'h00;
        take_close = 1'b0;
        len_add    = 1'b0;
        len_shift  = 1'b0;
        out_load   = 1'b0;
        n_pad      = r_pad;
        unique case (r_state)
            ST_IDLE: begin
                o_pop    = i_head.valid;
                put_en   = i_head.valid && i_head.req.byte_valid;
                put_byte = i_head.req.data_byte;
                len_add  = put_en;
                if (i_head.valid && i_head.req.end_of_message) begin
                    take_close = 1'b1;
                    n_pad      = PAD_MARK;
                end
            end
            ST_PAD: begin
                put_en = 1'b1;
                unique case (r_pad)
                    PAD_MARK: begin
                        put_byte = PAD_BYTE;
                        n_pad    = (fill_next == LEN_POS) ? PAD_LEN : PAD_ZERO;
                    end
                    PAD_ZERO: begin
                        put_byte = 8'h00;
                        n_pad    = (fill_next == LEN_POS) ? PAD_LEN : PAD_ZERO;
                    end
                    PAD_LEN: begin
                        put_byte  = r_len[63:56];
                        len_shift = 1'b1;
                        n_pad     = (r_len_cnt == LAST_IDX) ? PAD_DONE : PAD_LEN;
                    end
                    PAD_DONE: begin
                        put_en = 1'b0;
                    end
                    default: put_en = 1'b0;
                endcase
            end
            ST_EMIT: begin
                out_load = !r_out_valid || !i_stall;
            end
            default: begin
                put_en = 1'b0;
            end
        endcase
    end

    assign restart = out_load && (r_emit_idx == LAST_IDX);

    // one round of the compression
    assign w_cur = r_blk[511:480];
    assign w_new = sml1(r_blk[63:32]) + r_blk[223:192] + sml0(r_blk[479:448]) + w_cur;
    assign t1    = r_wv[7] + big1(r_wv[4]) + ((r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]))
                 + K_TABLE[r_round] + w_cur;
    assign t2    = big0(r_wv[0])
                 + ((r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pad       <= PAD_MARK;
            r_closing   <= 1'b0;
            r_fill      <= '0;
            r_len       <= '0;
            r_len_cnt   <= '0;
            r_round     <= '0;
            r_emit_idx  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= IV_TABLE[i];
            end
        end else begin
            r_state <= n_state;
            r_pad   <= n_pad;
            if (take_close) begin
                r_closing <= 1'b1;
                r_len_cnt <= '0;
            end
            if (put_en) begin
                r_fill <= fill_next;
            end
            if (len_add) begin
                r_len <= r_len + 64'd8;
            end else if (len_shift) begin
                r_len     <= {r_len[55:0], 8'h00};
                r_len_cnt <= r_len_cnt + 3'd1;
            end
            if (r_state == ST_ROUND) begin
                r_round <= r_round + 6'd1;
            end
            if (r_state == ST_FOLD) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_wv[i];
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_emit_idx  <= r_emit_idx + 3'd1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (restart) begin
                r_closing <= 1'b0;
                r_len     <= '0;
                r_fill    <= '0;
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= IV_TABLE[i];
                end
            end
        end
    end

    // block buffer, round registers and output word
    always_ff @(posedge i_clk) begin
        if (put_en) begin
            r_blk <= {r_blk[503:0], put_byte};
        end else if (r_state == ST_ROUND) begin
            r_blk <= {r_blk[479:0], w_new};
        end
        if (blk_full) begin
            for (int i = 0; i < 8; i++) begin
                r_wv[i] <= r_chain[i];
            end
        end else if (r_state == ST_ROUND) begin
            r_wv[7] <= r_wv[6];
            r_wv[6] <= r_wv[5];
            r_wv[5] <= r_wv[4];
            r_wv[4] <= r_wv[3] + t1;
            r_wv[3] <= r_wv[2];
            r_wv[2] <= r_wv[1];
            r_wv[1] <= r_wv[0];
            r_wv[0] <= t1 + t2;
        end
        if (out_load) begin
            r_out.digest_word <= r_chain[r_emit_idx];
            r_out.word_index  <= r_emit_idx;
            r_out.last_word   <= (r_emit_idx == LAST_IDX);
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

// ===== hw/rtl/sha256_stream_hasher_top.sv =====
// SHA-256 hasher over a byte stream.
// Input channel (i_valid / o_stall / i_req): one request per message byte, with
//   byte_valid marking a data byte and end_of_message closing the message. A
//   request with both flags set appends its byte, then closes. A request with
//   neither flag is taken and dropped.
// Output channel (o_valid / i_stall / o_rsp): on each close, eight digest words,
//   word_index 0 first, last_word set on the eighth.
// Throughput: one data byte per cycle while the engine is idle; each 64th byte
//   holds the flow for the 64 rounds of the single round unit and the fold into
//   the chaining value. After a close, the pad and length bytes go in one per
//   cycle (9 to 72 bytes) apart from each filled block's rounds and fold, then
//   the eight words leave one per cycle while i_stall is low.
// A four-deep request queue lets the sender run ahead while the engine is busy.
// A registered output word lets the engine load the next word while the
//   receiver takes the current one; while i_stall is high the word holds and
//   the engine waits.
// Reset clears the queue, the length and fill counters and the output valid, and
//   loads the initial hash values.
module sha256_stream_hasher_top import shs_pkg::*; #(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_req  i_req,
    output logic     o_valid,
    input  logic     i_stall,
    output t_out_rsp o_rsp
);

    t_queue_head head;
    logic        pop;

    // accept and classify requests, queue them for the engine
    shs_front #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_head  (head),
        .i_pop   (pop)
    );

    // pack bytes, pad, compress and emit the digest
    shs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== hw/rtl/shs_checker.sv =====
`include "sha256_stream_hasher_top_assert.svh"

module shs_checker import shs_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_out_valid,
    input logic     i_out_stall,
    input t_out_rsp i_out_rsp
);

    `SHS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_rsp), "stalled digest word changed")

    `SHS_ASSERT_NOW(a_last_flag, i_clk, i_rst_n, i_out_valid, i_out_rsp.last_word == (i_out_rsp.word_index == LAST_IDX), "last_word disagrees with word_index")

    `SHS_ASSERT_NEXT(a_index_step, i_clk, i_rst_n, i_out_valid && !i_out_stall && !i_out_rsp.last_word, !i_out_valid || i_out_rsp.word_index == $past(i_out_rsp.word_index) + 3'd1, "digest words out of order")

    `SHS_ASSERT_NEXT(a_index_wrap, i_clk, i_rst_n, i_out_valid && !i_out_stall && i_out_rsp.last_word, !i_out_valid || i_out_rsp.word_index == 3'd0, "digest does not start at word zero")

    `SHS_ASSERT_AFTER_RESET(a_reset_quiet, i_clk, i_rst_n, !i_out_valid, "output valid after reset")

endmodule

bind sha256_stream_hasher_top shs_checker u_shs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_out_rsp   (o_rsp)
);

// ===== tb/sv/tb.sv =====
module tb;
    import shs_pkg::*;

    // Known digests, easy to read off the standard: the empty message and "abc".
    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    localparam int RANDOM_REQS  = 175;
    localparam int DRAIN_CYCLES = 250;     // drain time after the worst-case close
    localparam int CYCLE_LIMIT  = 400000;

    // One directed row: expected digest (used only when known is set), then the request.
    typedef struct packed {
        logic [255:0] digest;
        logic         known;
        t_in_req      req;
    } t_dir_row;

    localparam int DIR_ROWS = 17;
    localparam t_dir_row DIR_STIM [DIR_ROWS] = '{
        // close right after reset, no data: digest of the empty message
        '{EMPTY_DIGEST, 1'b1, '{8'h00, 1'b0, 1'b1}},
        '{256'h0,       1'b0, '{8'h61, 1'b1, 1'b0}},
        '{256'h0,       1'b0, '{8'h62, 1'b1, 1'b0}},
        // neither flag in mid message: drop it, the message goes on
        '{256'h0,       1'b0, '{8'h5A, 1'b0, 1'b0}},
        // last byte and close in one request
        '{ABC_DIGEST,   1'b1, '{8'h63, 1'b1, 1'b1}},
        // neither flag between messages
        '{256'h0,       1'b0, '{8'hFF, 1'b0, 1'b0}},
        // close only, its data byte must be ignored
        '{EMPTY_DIGEST, 1'b1, '{8'hFF, 1'b0, 1'b1}},
        '{256'h0,       1'b0, '{8'h00, 1'b1, 1'b0}},
        '{256'h0,       1'b0, '{8'hFF, 1'b1, 1'b0}},
        '{256'h0,       1'b0, '{8'h80, 1'b1, 1'b0}},
        '{256'h0,       1'b0, '{8'h7F, 1'b1, 1'b0}},
        '{256'h0,       1'b0, '{8'h01, 1'b1, 1'b1}},
        '{256'h0,       1'b0, '{8'hFF, 1'b1, 1'b1}},
        '{256'h0,       1'b0, '{8'h00, 1'b1, 1'b1}},
        '{256'h0,       1'b0, '{8'hAA, 1'b1, 1'b0}},
        '{256'h0,       1'b0, '{8'h55, 1'b1, 1'b0}},
        '{256'h0,       1'b0, '{8'hC3, 1'b0, 1'b1}}
    };

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    t_in_req  i_req   = '0;
    logic     i_stall = 1'b0;
    logic     o_stall;
    logic     o_valid;
    t_out_rsp o_rsp;

    sha256_stream_hasher_top u_top (
        .i_clk,
        .i_rst_n,
        .i_valid,
        .o_stall,
        .i_req,
        .o_valid,
        .i_stall,
        .o_rsp
    );

    // Hasher state as the predictor tracks it.
    logic [31:0] hash_h [8];
    logic [31:0] msg_block [16];
    logic [5:0]  block_fill;
    logic [63:0] msg_bits;

    // Digest words still owed by the block, oldest first.
    t_out_rsp digest_words_due [$];

    int mismatches  = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int random_reqs = 0;

    t_stall_mode stall_mode  = STALL_NONE;
    logic [6:0]  stall_phase = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void sha_restart();
        hash_h     = IV_TABLE;
        block_fill = '0;
        msg_bits   = '0;
    endfunction

    // Run the 64 rounds over msg_block and fold the result into hash_h.
    function automatic void sha_compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = msg_block[i];
        for (int i = 16; i < 64; i++)
            w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        v = hash_h;
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[r] + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--)
                v[j] = v[j-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
            hash_h[j] = hash_h[j] + v[j];
    endfunction

    // Place one byte big-endian; compress once the block is full.
    function automatic void sha_absorb_byte(input logic [7:0] b);
        int sh;
        sh = 24 - 8 * int'(block_fill[1:0]);
        msg_block[block_fill[5:2]][sh +: 8] = b;
        block_fill = block_fill + 6'd1;
        if (block_fill == '0)
            sha_compress();
    endfunction

    // Advance the predictor by one request; return 1 with the digest on a close.
    function automatic logic sha_take_req(input t_in_req r, output logic [255:0] digest);
        logic [63:0] len;
        digest = '0;
        if (r.byte_valid) begin
            sha_absorb_byte(r.data_byte);
            msg_bits = msg_bits + 64'd8;
        end
        if (!r.end_of_message)
            return 1'b0;
        len = msg_bits;
        sha_absorb_byte(PAD_BYTE);
        while (block_fill != LEN_POS)
            sha_absorb_byte(8'h00);
        for (int n = 7; n >= 0; n--)
            sha_absorb_byte(len[8*n +: 8]);
        for (int k = 0; k < 8; k++)
            digest[255 - 32*k -: 32] = hash_h[k];
        sha_restart();
        return 1'b1;
    endfunction

    // Offer one request, hold it until taken, queue the digest words it owes,
    // then either stay in the burst or drop valid for a random gap.
    task automatic issue_req(input t_in_req r, input logic known,
                             input logic [255:0] known_digest);
        logic [255:0] digest;
        t_out_rsp     word;
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        if (sha_take_req(r, digest)) begin
            // typed-in digests override the predictor on the directed rows
            if (known)
                digest = known_digest;
            for (int k = 0; k < 8; k++) begin
                word.digest_word = digest[255 - 32*k -: 32];
                word.word_index  = 3'(k);
                word.last_word   = (word.word_index == LAST_IDX);
                digest_words_due.push_back(word);
            end
        end
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            // now and then run a long burst with no gaps at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 10);
        end else begin
            burst_left--;
        end
    endtask

    // Drop valid and hold off until every owed digest word has come back.
    task automatic hold_until_drained();
        if (i_valid)
            i_valid <= 1'b0;
        while (digest_words_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Stimulus: reset, directed rows, then random messages.
    initial begin
        t_in_req     req;
        int          msg_len;
        int          pick;
        logic        close_with_data;
        sha_restart();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++)
            issue_req(DIR_STIM[i].req, DIR_STIM[i].known, DIR_STIM[i].digest);
        hold_until_drained();

        while (random_reqs < RANDOM_REQS) begin
            // pick a length: mostly short, often around the pad boundary, a few
            // spanning two or three blocks
            pick = $urandom_range(0, 99);
            if (pick < 25)
                msg_len = $urandom_range(int'(LEN_POS) - 3, int'(LEN_POS) + 10);
            else if (pick < 32)
                msg_len = $urandom_range(116, 130);
            else
                msg_len = $urandom_range(0, 12);
            close_with_data = (msg_len > 0) && ($urandom_range(0, 1) == 1);

            for (int n = 0; n < msg_len; n++) begin
                // sprinkle requests that carry neither flag; they must be dropped
                if ($urandom_range(0, 15) == 0) begin
                    req.data_byte      = 8'($urandom);
                    req.byte_valid     = 1'b0;
                    req.end_of_message = 1'b0;
                    issue_req(req, 1'b0, '0);
                end
                req.data_byte      = 8'($urandom);
                req.byte_valid     = 1'b1;
                req.end_of_message = close_with_data && (n == msg_len - 1);
                issue_req(req, 1'b0, '0);
                random_reqs++;
            end
            if (!close_with_data) begin
                req.data_byte      = 8'($urandom);
                req.byte_valid     = 1'b0;
                req.end_of_message = 1'b1;
                issue_req(req, 1'b0, '0);
                random_reqs++;
            end
            if ($urandom_range(0, 6) == 0)
                hold_until_drained();
        end

        hold_until_drained();
        // give a stray word time to show up after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: stall on a pattern whose mode is redrawn each time stall_phase wraps, and
    // check each digest word taken against the oldest owed one.
    always @(posedge i_clk) begin : rsp_check
        t_out_rsp want;
        cycle_count <= cycle_count + 1;
        stall_phase <= stall_phase + 7'd1;
        if (stall_phase == '0)
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 9) < 7);
            default:     i_stall <= stall_phase[2];
        endcase

        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (digest_words_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected digest word: expected none, actual %h idx %0d last %0b",
                         $time, o_rsp.digest_word, o_rsp.word_index, o_rsp.last_word);
            end else begin
                want = digest_words_due.pop_front();
                if (o_rsp.digest_word !== want.digest_word
                        || o_rsp.word_index !== want.word_index
                        || o_rsp.last_word !== want.last_word) begin
                    mismatches++;
                    $display("%0t: digest word mismatch: expected %h idx %0d last %0b,",
                             $time, want.digest_word, want.word_index, want.last_word,
                             " actual %h idx %0d last %0b",
                             o_rsp.digest_word, o_rsp.word_index, o_rsp.last_word);
                end
            end
        end
    end

    // Watchdog: end a hung run.
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
